FILE: rtl/core/waveform_minmax_column_decimator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min/max column decimator
// Shared concurrent assertion forms, all sampled on clk.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_MINMAX_COLUMN_DECIMATOR_DEFINES_SVH
`define WAVEFORM_MINMAX_COLUMN_DECIMATOR_DEFINES_SVH

// Checked only while out of reset
`define WMCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define WMCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/wmcd_pkg.sv
// ----------------------------------------------------------------------------
// wmcd_pkg
// Types, constants and pixel math shared by the column decimator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmcd_pkg;

    // Field and state widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAME_BITS  = 24;
    localparam int ERR_BITS    = 25;
    localparam int ACC_BITS    = ERR_BITS + 1;
    localparam int DIM_BITS    = 13;   // width/height registers and cur_x
    localparam int PIX_BITS    = 12;   // pixel coordinates on the output

    // Stream widths
    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 80;
    localparam int M_TUSER_BITS = 3;
    localparam int CFG_IDX_BITS = 3;

    // Clamp limits
    localparam logic [DIM_BITS-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [DIM_BITS-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [PIX_BITS-1:0] PIX_MAX    = 12'd4095;

    // Register reset values
    localparam logic [DIM_BITS-1:0]   RST_WIDTH_PX   = 13'd512;
    localparam logic [DIM_BITS-1:0]   RST_HEIGHT_PX  = 13'd256;
    localparam logic [FRAME_BITS-1:0] RST_VIEW_FIRST = 24'd0;
    localparam logic [FRAME_BITS-1:0] RST_VIEW_END   = 24'd1024;
    localparam logic [FRAME_BITS-1:0] RST_PLAY_FIRST = 24'd0;
    localparam logic [FRAME_BITS-1:0] RST_PLAY_LAST  = 24'd1023;
    localparam logic [FRAME_BITS-1:0] RST_LOOP_FIRST = 24'd0;
    localparam logic [FRAME_BITS-1:0] RST_LOOP_LAST  = 24'd1023;

    // Job queue depth between front and back end
    localparam int JOB_FIFO_DEPTH = 2;
    localparam int JOB_PTR_BITS   = $clog2(JOB_FIFO_DEPTH);
    localparam int JOB_CNT_BITS   = $clog2(JOB_FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH_PX   = 3'd0,
        CFG_HEIGHT_PX  = 3'd1,
        CFG_VIEW_FIRST = 3'd2,
        CFG_VIEW_END   = 3'd3,
        CFG_PLAY_FIRST = 3'd4,
        CFG_PLAY_LAST  = 3'd5,
        CFG_LOOP_FIRST = 3'd6,
        CFG_LOOP_LAST  = 3'd7
    } cfg_index_t;

    // Frame zone classes
    typedef enum logic [1:0] {
        ZONE_DEAD = 2'd0,
        ZONE_PLAY = 2'd1,
        ZONE_LOOP = 2'd2
    } zone_t;

    typedef enum logic {
        F_READY,
        F_WALK
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LO,
        B_HI,
        B_FROM,
        B_OUT
    } back_state_t;

    // Configuration register file
    typedef struct packed {
        logic [DIM_BITS-1:0]   width_px;
        logic [DIM_BITS-1:0]   height_px;
        logic [FRAME_BITS-1:0] view_first;
        logic [FRAME_BITS-1:0] view_end;
        logic [FRAME_BITS-1:0] play_first;
        logic [FRAME_BITS-1:0] play_last;
        logic [FRAME_BITS-1:0] loop_first;
        logic [FRAME_BITS-1:0] loop_last;
    } cfg_t;

    // One drawing job: geometry settled, raw samples still to be scaled
    typedef struct packed {
        logic                          upsample;
        logic [PIX_BITS-1:0]           column_x;
        logic                          link_valid;
        logic [PIX_BITS-1:0]           link_x_from;
        logic                          link_to_high;  // connector ends at the max
        logic signed [SAMPLE_BITS-1:0] s_low;
        logic signed [SAMPLE_BITS-1:0] s_high;
        logic signed [SAMPLE_BITS-1:0] s_from;
        logic                          py_init;       // previous point y was reset
        logic [PIX_BITS-1:0]           py_init_val;
        zone_t                         zone;
    } job_t;

    // One finished result
    typedef struct packed {
        logic [PIX_BITS-1:0] column_x;
        logic [PIX_BITS-1:0] y_low;
        logic [PIX_BITS-1:0] y_high;
        logic                link_valid;
        logic [PIX_BITS-1:0] link_x_from;
        logic [PIX_BITS-1:0] link_y_from;
        logic [PIX_BITS-1:0] link_y_to;
        zone_t               zone;
        logic                upsample_mode;
    } result_t;

    // Width with zero read as one and clamped to the column limit
    function automatic logic [DIM_BITS-1:0] eff_width(input logic [DIM_BITS-1:0] w);
        logic [DIM_BITS-1:0] r;
        r = w;
        if (w == '0)
            r = DIM_BITS'(1);
        else if (w > MAX_WIDTH)
            r = MAX_WIDTH;
        return r;
    endfunction

    // Height clamped to the row limit
    function automatic logic [DIM_BITS-1:0] eff_height(input logic [DIM_BITS-1:0] h);
        return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endfunction

    // Pixel y of a sample: ((s + half scale) * h) >> SAMPLE_BITS, saturated
    function automatic logic [PIX_BITS-1:0] ypix(input logic signed [SAMPLE_BITS-1:0] s,
                                                 input logic [DIM_BITS-1:0] h);
        logic [SAMPLE_BITS-1:0]          off;
        logic [SAMPLE_BITS+DIM_BITS-1:0] prod;
        logic [DIM_BITS-1:0]             y;
        off  = {~s[SAMPLE_BITS-1], s[SAMPLE_BITS-2:0]};
        prod = (SAMPLE_BITS+DIM_BITS)'(off) * (SAMPLE_BITS+DIM_BITS)'(h);
        y    = prod[SAMPLE_BITS+DIM_BITS-1:SAMPLE_BITS];
        return (y > DIM_BITS'(PIX_MAX)) ? PIX_MAX : y[PIX_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/wmcd_job_fifo.sv
// ----------------------------------------------------------------------------
// wmcd_job_fifo
// Short queue of drawing jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcd_job_fifo
    import wmcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic not_empty
);

    job_t                    entries_reg [JOB_FIFO_DEPTH];
    logic [JOB_PTR_BITS-1:0] wr_ptr_reg;
    logic [JOB_PTR_BITS-1:0] rd_ptr_reg;
    logic [JOB_CNT_BITS-1:0] count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == JOB_CNT_BITS'(JOB_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = entries_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == JOB_PTR_BITS'(JOB_FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + JOB_PTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == JOB_PTR_BITS'(JOB_FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + JOB_PTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + JOB_CNT_BITS'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - JOB_CNT_BITS'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: rtl/core/wmcd_front.sv
// ----------------------------------------------------------------------------
// wmcd_front
// Takes samples, keeps the sweep state and settles the geometry of each
// column or segment; pushes one drawing job per result into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcd_front
    import wmcd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_sweep,
    output logic                          job_push,
    output job_t                          job,
    input  logic                          job_full
);

    front_state_t state_reg, state_next;

    // Sweep state
    logic                          run_valid_reg, run_valid_next;
    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic signed [SAMPLE_BITS-1:0] prev_min_reg, prev_min_next;
    logic signed [SAMPLE_BITS-1:0] prev_max_reg, prev_max_next;
    logic [PIX_BITS-1:0]           prev_x_reg, prev_x_next;
    logic [DIM_BITS-1:0]           cur_x_reg, cur_x_next;
    logic [ERR_BITS-1:0]           err_reg, err_next;
    logic [FRAME_BITS-1:0]         frame_reg, frame_next;
    logic                          py_init_reg, py_init_next;
    logic [PIX_BITS-1:0]           py_val_reg, py_val_next;

    // Upsample walk
    logic [ACC_BITS-1:0]           walk_acc_reg, walk_acc_next;
    logic [DIM_BITS-1:0]           walk_x_reg, walk_x_next;
    logic signed [SAMPLE_BITS-1:0] walk_sample_reg, walk_sample_next;
    zone_t                         walk_zone_reg, walk_zone_next;

    logic [DIM_BITS-1:0]   w;
    logic [DIM_BITS-1:0]   h;
    logic [FRAME_BITS-1:0] vis;
    logic                  reversed;
    logic                  up_mode;
    logic                  accept;

    // State as seen after an optional sweep restart
    logic                          run_valid_e;
    logic signed [SAMPLE_BITS-1:0] prev_min_e;
    logic signed [SAMPLE_BITS-1:0] prev_max_e;
    logic [PIX_BITS-1:0]           prev_x_e;
    logic [DIM_BITS-1:0]           cur_x_e;
    logic [ERR_BITS-1:0]           err_e;
    logic [FRAME_BITS-1:0]         frame_e;
    logic                          py_init_e;
    logic [PIX_BITS-1:0]           py_val_e;

    logic                          active;
    logic                          walk_go;
    zone_t                         zone;
    logic signed [SAMPLE_BITS-1:0] new_min;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [ACC_BITS-1:0]           err_sum;
    logic [ERR_BITS-1:0]           err1;
    logic [ERR_BITS-1:0]           err2;
    logic                          emit;
    logic                          link_below;
    logic                          link_above;
    logic                          walk_done;
    logic                          walk_abort;
    logic [ACC_BITS-1:0]           walk_rem;
    logic [DIM_BITS:0]             walk_x_inc;
    logic                          dec_push;
    logic                          up_push;

    // Effective dimensions and view
    assign w        = eff_width(cfg.width_px);
    assign h        = eff_height(cfg.height_px);
    assign vis      = cfg.view_end - cfg.view_first;
    assign reversed = (cfg.view_end < cfg.view_first);
    assign up_mode  = (FRAME_BITS'(w) >= vis);
    assign accept   = in_valid && in_ready;

    // Sweep restart overlay
    always_comb
    begin
        run_valid_e = in_sweep ? 1'b0 : run_valid_reg;
        prev_min_e  = in_sweep ? '0 : prev_min_reg;
        prev_max_e  = in_sweep ? '0 : prev_max_reg;
        prev_x_e    = in_sweep ? '0 : prev_x_reg;
        cur_x_e     = in_sweep ? '0 : cur_x_reg;
        err_e       = in_sweep ? '0 : err_reg;
        frame_e     = in_sweep ? cfg.view_first : frame_reg;
        py_init_e   = in_sweep ? 1'b1 : py_init_reg;
        py_val_e    = in_sweep ? h[DIM_BITS-1:1] : py_val_reg;
    end

    assign active  = !reversed && (frame_e < cfg.view_end);
    assign walk_go = accept && active && up_mode && (cur_x_e < w);

    // Zone of the current frame
    always_comb
    begin
        if ((frame_e < cfg.play_first) || (frame_e > cfg.play_last))
            zone = ZONE_DEAD;
        else if ((frame_e >= cfg.loop_first) && (frame_e <= cfg.loop_last))
            zone = ZONE_LOOP;
        else
            zone = ZONE_PLAY;
    end

    // Decimation: running extremes, accumulator and connector choice
    assign new_min    = (!run_valid_e || (in_sample < run_min_reg)) ? in_sample : run_min_reg;
    assign new_max    = (!run_valid_e || (in_sample > run_max_reg)) ? in_sample : run_max_reg;
    assign err_sum    = ACC_BITS'(err_e) + ACC_BITS'(w);
    assign err1       = err_sum[ERR_BITS-1:0];
    assign emit       = (err1 >= ERR_BITS'(vis));
    assign err2       = err1 - ERR_BITS'(vis);
    assign link_below = (new_max < prev_min_e);
    assign link_above = !link_below && (new_min > prev_max_e);

    // Upsample walk step
    assign walk_done  = (walk_acc_reg >= ACC_BITS'(w));
    assign walk_x_inc = {1'b0, walk_x_reg} + (DIM_BITS+1)'(1);
    assign walk_abort = !walk_done && (walk_x_inc >= {1'b0, w});
    assign walk_rem   = walk_acc_reg - ACC_BITS'(w);

    assign dec_push = (state_reg == F_READY) && accept && active && !up_mode && emit;
    assign up_push  = (state_reg == F_WALK) && walk_done && !job_full;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_READY:
            begin
                if (walk_go)
                    state_next = F_WALK;
            end
            F_WALK:
            begin
                if (up_push || walk_abort)
                    state_next = F_READY;
            end
            default: state_next = F_READY;
        endcase
    end

    // Handshake and job outputs
    always_comb
    begin
        in_ready = (state_reg == F_READY) && !job_full;
        job_push = dec_push || up_push;
        job      = '0;
        if (state_reg == F_WALK)
        begin
            job.upsample    = 1'b1;
            job.column_x    = walk_x_reg[PIX_BITS-1:0];
            job.link_valid  = 1'b1;
            job.link_x_from = prev_x_reg;
            job.s_low       = walk_sample_reg;
            job.s_high      = walk_sample_reg;
            job.s_from      = walk_sample_reg;
            job.py_init     = py_init_reg;
            job.py_init_val = py_val_reg;
            job.zone        = walk_zone_reg;
        end
        else
        begin
            job.column_x     = cur_x_e[PIX_BITS-1:0];
            job.link_valid   = link_below || link_above;
            job.link_x_from  = (link_below || link_above) ? prev_x_e : '0;
            job.link_to_high = link_below;
            job.s_low        = new_min;
            job.s_high       = new_max;
            job.s_from       = link_below ? prev_min_e : prev_max_e;
            job.zone         = zone;
        end
    end

    // Sweep state update
    always_comb
    begin
        run_valid_next   = run_valid_reg;
        run_min_next     = run_min_reg;
        run_max_next     = run_max_reg;
        prev_min_next    = prev_min_reg;
        prev_max_next    = prev_max_reg;
        prev_x_next      = prev_x_reg;
        cur_x_next       = cur_x_reg;
        err_next         = err_reg;
        frame_next       = frame_reg;
        py_init_next     = py_init_reg;
        py_val_next      = py_val_reg;
        walk_acc_next    = walk_acc_reg;
        walk_x_next      = walk_x_reg;
        walk_sample_next = walk_sample_reg;
        walk_zone_next   = walk_zone_reg;

        if ((state_reg == F_READY) && accept)
        begin
            run_valid_next = run_valid_e;
            prev_min_next  = prev_min_e;
            prev_max_next  = prev_max_e;
            prev_x_next    = prev_x_e;
            cur_x_next     = cur_x_e;
            err_next       = err_e;
            frame_next     = frame_e;
            py_init_next   = py_init_e;
            py_val_next    = py_val_e;
            if (walk_go)
            begin
                walk_acc_next    = ACC_BITS'(err_e) + ACC_BITS'(vis);
                walk_x_next      = cur_x_e;
                walk_sample_next = in_sample;
                walk_zone_next   = zone;
            end
            else if (active && !up_mode)
            begin
                run_min_next = new_min;
                run_max_next = new_max;
                frame_next   = frame_e + FRAME_BITS'(1);
                if (emit)
                begin
                    err_next       = err2;
                    prev_x_next    = cur_x_e[PIX_BITS-1:0];
                    cur_x_next     = cur_x_e + DIM_BITS'(1);
                    prev_min_next  = new_min;
                    prev_max_next  = new_max;
                    run_valid_next = 1'b0;
                end
                else
                begin
                    err_next       = err1;
                    run_valid_next = 1'b1;
                end
            end
        end
        else if (state_reg == F_WALK)
        begin
            if (up_push)
            begin
                err_next     = walk_rem[ERR_BITS-1:0];
                prev_x_next  = walk_x_reg[PIX_BITS-1:0];
                cur_x_next   = walk_x_inc[DIM_BITS-1:0];
                frame_next   = frame_reg + FRAME_BITS'(1);
                py_init_next = 1'b0;
            end
            else if (walk_abort)
            begin
                cur_x_next = w;
            end
            else if (!walk_done)
            begin
                walk_x_next   = walk_x_inc[DIM_BITS-1:0];
                walk_acc_next = walk_acc_reg + ACC_BITS'(vis);
            end
        end
    end

    // Control and sweep registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_READY;
            run_valid_reg <= 1'b0;
            run_min_reg   <= '0;
            run_max_reg   <= '0;
            prev_min_reg  <= '0;
            prev_max_reg  <= '0;
            prev_x_reg    <= '0;
            cur_x_reg     <= '0;
            err_reg       <= '0;
            frame_reg     <= RST_VIEW_FIRST;
            py_init_reg   <= 1'b1;
            py_val_reg    <= RST_HEIGHT_PX[DIM_BITS-1:1];
        end
        else
        begin
            state_reg     <= state_next;
            run_valid_reg <= run_valid_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            prev_min_reg  <= prev_min_next;
            prev_max_reg  <= prev_max_next;
            prev_x_reg    <= prev_x_next;
            cur_x_reg     <= cur_x_next;
            err_reg       <= err_next;
            frame_reg     <= frame_next;
            py_init_reg   <= py_init_next;
            py_val_reg    <= py_val_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        walk_acc_reg    <= walk_acc_next;
        walk_x_reg      <= walk_x_next;
        walk_sample_reg <= walk_sample_next;
        walk_zone_reg   <= walk_zone_next;
    end

endmodule

FILE: rtl/core/wmcd_back.sv
// ----------------------------------------------------------------------------
// wmcd_back
// Pops drawing jobs, scales their samples to pixel y on one shared
// multiplier and hands finished results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmcd_back
    import wmcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DIM_BITS-1:0] height_px,
    input  logic                job_valid,
    input  job_t                job,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             out_result
);

    back_state_t state_reg, state_next;

    job_t                job_reg;
    logic [PIX_BITS-1:0] y_lo_reg;
    logic [PIX_BITS-1:0] y_hi_reg;
    logic [PIX_BITS-1:0] y_from_reg;
    logic [PIX_BITS-1:0] prev_y_reg;
    logic                out_valid_reg;
    result_t             result_reg;

    logic [DIM_BITS-1:0]           h;
    logic signed [SAMPLE_BITS-1:0] mul_sample;
    logic [PIX_BITS-1:0]           y_calc;
    logic                          out_free;
    logic                          load_out;
    result_t                       result_next;

    assign h          = eff_height(height_px);
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // Shared scaler: one sample per step
    always_comb
    begin
        case (state_reg)
            B_HI:    mul_sample = job_reg.s_high;
            B_FROM:  mul_sample = job_reg.s_from;
            default: mul_sample = job_reg.s_low;
        endcase
    end

    assign y_calc = ypix(mul_sample, h);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                    state_next = B_LO;
            end
            B_LO:
            begin
                state_next = job_reg.upsample ? B_OUT : B_HI;
            end
            B_HI:
            begin
                state_next = job_reg.link_valid ? B_FROM : B_OUT;
            end
            B_FROM:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        job_pop  = (state_reg == B_IDLE) && job_valid;
        load_out = (state_reg == B_OUT) && out_free;
    end

    // Result assembly
    always_comb
    begin
        result_next             = '0;
        result_next.column_x    = job_reg.column_x;
        result_next.zone        = job_reg.zone;
        result_next.link_valid  = job_reg.link_valid;
        result_next.link_x_from = job_reg.link_x_from;
        result_next.y_low       = y_lo_reg;
        if (job_reg.upsample)
        begin
            result_next.y_high        = y_lo_reg;
            result_next.link_y_from   = job_reg.py_init ? job_reg.py_init_val : prev_y_reg;
            result_next.link_y_to     = y_lo_reg;
            result_next.upsample_mode = 1'b1;
        end
        else
        begin
            result_next.y_high = y_hi_reg;
            if (job_reg.link_valid)
            begin
                result_next.link_y_from = y_from_reg;
                result_next.link_y_to   = job_reg.link_to_high ? y_hi_reg : y_lo_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Job, scaled values and output payload
    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        if (state_reg == B_LO)
            y_lo_reg <= y_calc;
        if (state_reg == B_HI)
            y_hi_reg <= y_calc;
        if (state_reg == B_FROM)
            y_from_reg <= y_calc;
        if (load_out)
        begin
            result_reg <= result_next;
            if (job_reg.upsample)
                prev_y_reg <= y_lo_reg;
        end
    end

endmodule

FILE: rtl/core/waveform_minmax_column_decimator.sv
// ----------------------------------------------------------------------------
// waveform_minmax_column_decimator
// Min/max peak decimation of a sample sweep onto waveform pixel columns.
// ----------------------------------------------------------------------------
// Samples of one sweep enter on the s_ side; each gives at most one result on
// the m_ side, either a min/max column with an optional connector (more
// visible frames than columns) or a line segment (at least as many columns as
// frames). In decimation mode the front end takes a sample every cycle while
// the two-entry job queue has room. In upsample mode it takes a sample, then
// walks the error accumulator column by column, taking no new sample until
// the walk pushes its segment or passes the last column. The back end scales
// to pixel y one sample at a time on a single multiplier (a segment's low;
// a column's low, high and connector start if any); it sets the column rate.
// Registers are written through cfg_wen/cfg_index/cfg_data and take effect
// from the next sample; write them only while the block is idle.
`timescale 1ns / 1ps

module waveform_minmax_column_decimator
    import wmcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Sample stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // [15:0] sample_value
    input  logic                    s_tuser,   // [0] sweep_start
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [11:0] column_x, [23:12] y_low, [35:24] y_high, [36] link_valid,
    // [48:37] link_x_from, [60:49] link_y_from, [72:61] link_y_to, rest zero
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic [M_TUSER_BITS-1:0] m_tuser,   // [1:0] zone, [2] upsample_mode
    // Register writes
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]   cfg_data
);

    cfg_t    cfg_reg;
    logic    job_push;
    job_t    push_job;
    logic    job_full;
    logic    job_pop;
    job_t    pop_job;
    logic    job_valid;
    result_t result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_px   <= RST_WIDTH_PX;
            cfg_reg.height_px  <= RST_HEIGHT_PX;
            cfg_reg.view_first <= RST_VIEW_FIRST;
            cfg_reg.view_end   <= RST_VIEW_END;
            cfg_reg.play_first <= RST_PLAY_FIRST;
            cfg_reg.play_last  <= RST_PLAY_LAST;
            cfg_reg.loop_first <= RST_LOOP_FIRST;
            cfg_reg.loop_last  <= RST_LOOP_LAST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WIDTH_PX:   cfg_reg.width_px   <= cfg_data[DIM_BITS-1:0];
                CFG_HEIGHT_PX:  cfg_reg.height_px  <= cfg_data[DIM_BITS-1:0];
                CFG_VIEW_FIRST: cfg_reg.view_first <= cfg_data;
                CFG_VIEW_END:   cfg_reg.view_end   <= cfg_data;
                CFG_PLAY_FIRST: cfg_reg.play_first <= cfg_data;
                CFG_PLAY_LAST:  cfg_reg.play_last  <= cfg_data;
                CFG_LOOP_FIRST: cfg_reg.loop_first <= cfg_data;
                CFG_LOOP_LAST:  cfg_reg.loop_last  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: sweep state and geometry
    wmcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (signed'(s_tdata[SAMPLE_BITS-1:0])),
        .in_sweep  (s_tuser),
        .job_push  (job_push),
        .job       (push_job),
        .job_full  (job_full)
    );

    // Job queue
    wmcd_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (job_full),
        .pop       (job_pop),
        .pop_job   (pop_job),
        .not_empty (job_valid)
    );

    // Back end: pixel scaling and output register
    wmcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .height_px  (cfg_reg.height_px),
        .job_valid  (job_valid),
        .job        (pop_job),
        .job_pop    (job_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result packing
    assign m_tdata = {7'd0, result.link_y_to, result.link_y_from, result.link_x_from,
                      result.link_valid, result.y_high, result.y_low, result.column_x};
    assign m_tuser = {result.upsample_mode, result.zone};

endmodule

FILE: rtl/core/wmcd_checker.sv
// ----------------------------------------------------------------------------
// wmcd_checker
// Port-level checks on the result stream of the column decimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "waveform_minmax_column_decimator_defines.svh"

module wmcd_checker
    import wmcd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata,
    input logic [M_TUSER_BITS-1:0] m_tuser
);

    logic                                 stalled;
    logic [M_TDATA_BITS+M_TUSER_BITS-1:0] payload;
    logic                                 link_flag;
    logic                                 segment_ok;
    logic                                 geom_zero;
    logic                                 zone_ok;
    logic                                 pad_zero;

    assign stalled    = m_tvalid && !m_tready;
    assign payload    = {m_tuser, m_tdata};
    assign link_flag  = m_tdata[36];
    // point y on both extremes and at the connector end
    assign segment_ok = link_flag && (m_tdata[23:12] == m_tdata[35:24]) &&
                        (m_tdata[72:61] == m_tdata[23:12]);
    assign geom_zero  = (m_tdata[72:37] == '0);
    assign zone_ok    = (m_tuser[1:0] == ZONE_DEAD) || (m_tuser[1:0] == ZONE_PLAY) ||
                        (m_tuser[1:0] == ZONE_LOOP);
    assign pad_zero   = (m_tdata[79:73] == '0);

    // No result is offered while in reset
    `WMCD_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !m_tvalid, "result valid during reset")

    // A stalled result holds its payload
    `WMCD_ASSERT(a_out_hold, stalled |=> m_tvalid && $stable(payload), "stalled result changed")

    // Segments are single points with a connector ending at them
    `WMCD_ASSERT(a_segment_shape, m_tvalid && m_tuser[2] |-> segment_ok, "malformed segment")

    // Without a connector its geometry is zero
    `WMCD_ASSERT(a_no_link_zero, m_tvalid && !link_flag |-> geom_zero, "connector without link")

    // Only defined zone codes, padding stays zero
    `WMCD_ASSERT(a_zone_pad, m_tvalid |-> zone_ok && pad_zero, "bad zone or padding")

endmodule

bind waveform_minmax_column_decimator wmcd_checker u_wmcd_checker (.*);
